>>> hdl/x86sat_pkg.sv
// Package for the x86 segment address translate unit.
// Holds the request, result and inter-stage types and the operation/status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package x86sat_pkg;

    localparam int unsigned AddrW  = 64;
    localparam int unsigned HalfW  = 32;
    localparam int unsigned LimitW = 32;
    localparam int unsigned SelW   = 16;
    localparam int unsigned AttrW  = 7;

    // Operation codes; the fourth code behaves as an unchecked translate.
    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_CODE  = 2'd1;
    localparam logic [1:0] OP_RAW   = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Segment register indexes that keep their base in 64-bit mode.
    localparam logic [2:0] SEG_FS = 3'd4;
    localparam logic [2:0] SEG_GS = 3'd5;

    // Attribute bit positions.
    localparam int unsigned ATTR_S    = 4;
    localparam int unsigned ATTR_P    = 5;
    localparam int unsigned ATTR_G    = 6;
    localparam int unsigned ATTR_CODE = 3;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BOUNDS      = 2'd1,
        ST_NOT_PRESENT = 2'd2,
        ST_NOT_CODE    = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]        operation;
        logic              real_or_v86;
        logic              long_mode_active;
        logic              cs_long;
        logic [2:0]        seg_index;
        logic [SelW-1:0]   selector;
        logic [AddrW-1:0]  seg_base;
        logic [LimitW-1:0] seg_limit;
        logic [AttrW-1:0]  seg_attr;
        logic              hidden_valid;
        logic [AddrW-1:0]  address;
    } t_req;

    typedef struct packed {
        logic [AddrW-1:0] flat_address;
        t_status          status;
    } t_rsp;

    // Between the check stage and the merge stage.
    typedef struct packed {
        logic             vld;
        t_status          status;
        logic             is32;
        logic [HalfW-1:0] a_hi;
        logic [HalfW-1:0] b_hi;
        logic [HalfW:0]   sum_lo;
    } t_mid;

endpackage

`default_nettype wire

>>> hdl/x86sat_check.sv
// Check stage: descriptor checks, operand selection and low-half add.
// Depends on x86sat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module x86sat_check (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_vld,
    input  wire x86sat_pkg::t_req i_req,
    output x86sat_pkg::t_mid      o_mid
);

    logic                          r_vld;
    x86sat_pkg::t_mid              r_mid;
    x86sat_pkg::t_mid              n_mid;

    logic                          wide;
    logic                          present;
    logic                          expand_dn;
    logic                          off_gt_lim;
    logic                          off_gt_64k;
    logic                          code_ok_lim;
    logic                          fs_gs;
    logic [x86sat_pkg::AddrW-1:0]  op_a;
    logic [x86sat_pkg::AddrW-1:0]  op_b;
    logic                          is32;
    x86sat_pkg::t_status           status;

    always_comb begin
        wide        = i_req.long_mode_active & i_req.cs_long;
        present     = i_req.seg_attr[x86sat_pkg::ATTR_P];
        expand_dn   = (i_req.seg_attr[3:2] == 2'b01);
        off_gt_lim  = (|i_req.address[63:32]) || (i_req.address[31:0] > i_req.seg_limit);
        off_gt_64k  = |i_req.address[63:16];
        code_ok_lim = (i_req.address[31:0] <= i_req.seg_limit);
        fs_gs       = (i_req.seg_index == x86sat_pkg::SEG_FS)
                   || (i_req.seg_index == x86sat_pkg::SEG_GS);
    end

    always_comb begin
        status = x86sat_pkg::ST_OK;
        if (!i_req.real_or_v86) begin
            unique case (i_req.operation)
                x86sat_pkg::OP_CODE: begin
                    priority if (!present)
                        status = x86sat_pkg::ST_NOT_PRESENT;
                    else if (!i_req.seg_attr[x86sat_pkg::ATTR_S]
                             || !i_req.seg_attr[x86sat_pkg::ATTR_CODE])
                        status = x86sat_pkg::ST_NOT_CODE;
                    else if (!wide && !code_ok_lim)
                        status = x86sat_pkg::ST_BOUNDS;
                    else
                        status = x86sat_pkg::ST_OK;
                end
                x86sat_pkg::OP_DATA: begin
                    priority if (!present)
                        status = x86sat_pkg::ST_NOT_PRESENT;
                    else if (wide)
                        status = x86sat_pkg::ST_OK;
                    else if (expand_dn) begin
                        // Expand-down: valid offsets lie above the limit.
                        if ((!i_req.seg_attr[x86sat_pkg::ATTR_G] && off_gt_64k) || !off_gt_lim)
                            status = x86sat_pkg::ST_BOUNDS;
                    end else if (off_gt_lim)
                        status = x86sat_pkg::ST_BOUNDS;
                    else
                        status = x86sat_pkg::ST_OK;
                end
                x86sat_pkg::OP_RAW,
                x86sat_pkg::OP_SPARE: status = x86sat_pkg::ST_OK;
                default:              status = x86sat_pkg::ST_OK;
            endcase
        end
    end

    always_comb begin
        priority if (i_req.real_or_v86) begin
            op_a = {48'd0, i_req.address[15:0]};
            op_b = i_req.hidden_valid ? {32'd0, i_req.seg_base[31:0]}
                                      : {44'd0, i_req.selector, 4'd0};
            is32 = 1'b1;
        end else if (wide) begin
            // Only FS and GS keep their base in 64-bit mode, and never for code.
            op_a = i_req.address;
            op_b = (i_req.operation != x86sat_pkg::OP_CODE && fs_gs)
                 ? i_req.seg_base : '0;
            is32 = 1'b0;
        end else begin
            op_a = {32'd0, i_req.address[31:0]};
            op_b = {32'd0, i_req.seg_base[31:0]};
            is32 = 1'b1;
        end
    end

    always_comb begin
        n_mid        = r_mid;
        n_mid.vld    = i_vld;
        n_mid.status = status;
        n_mid.is32   = is32;
        n_mid.a_hi   = op_a[63:32];
        n_mid.b_hi   = op_b[63:32];
        n_mid.sum_lo = {1'b0, op_a[31:0]} + {1'b0, op_b[31:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mid <= n_mid;
    end

    always_comb begin
        o_mid     = r_mid;
        o_mid.vld = r_vld;
    end

endmodule

`default_nettype wire

>>> hdl/x86sat_merge.sv
// Merge stage: high-half add, 32-bit wrap and fault zeroing, result register.
// Depends on x86sat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module x86sat_merge (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire x86sat_pkg::t_mid i_mid,
    output logic                  o_valid,
    output x86sat_pkg::t_rsp      o_result
);

    logic                          r_valid;
    x86sat_pkg::t_rsp              r_result;
    x86sat_pkg::t_rsp              n_result;
    logic [x86sat_pkg::HalfW-1:0]  sum_hi;

    always_comb begin
        sum_hi = i_mid.a_hi + i_mid.b_hi + {31'd0, i_mid.sum_lo[32]};
        n_result.status = i_mid.status;
        // Drop the address on a failed check.
        if (i_mid.status != x86sat_pkg::ST_OK)
            n_result.flat_address = '0;
        else if (i_mid.is32)
            n_result.flat_address = {32'd0, i_mid.sum_lo[31:0]};
        else
            n_result.flat_address = {sum_hi, i_mid.sum_lo[31:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_mid.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> hdl/x86sat_pkg_dummy_never.sv
// Stage-free helper is not needed; this file intentionally left minimal.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
`default_nettype wire

>>> hdl/x86_segment_address_translate_unit.sv
// x86 segment address translate unit: top level with input register and checks.
// Depends on x86sat_pkg, x86sat_check and x86sat_merge.
//
// Usage:
//   Drive a request on i_item and raise start for one cycle per transfer.
//   busy is always low: a new request may be given in every clock cycle.
//   Each request yields exactly one result on o_result, marked by o_valid
//   for one cycle; results leave in request order.
//   Throughput: one request per cycle, as no stage ever holds; the latency
//   is set by three register stages (input register, check/low-add stage,
//   high-add/result stage).
//   The receiver cannot hold results off; none is needed, as the pipeline
//   never stalls.
//   Reset (i_rst_n low, synchronous) clears every stage valid bit; requests
//   in flight are dropped and o_valid stays low until new requests arrive.
//   status: ok, out of bounds, not present, not code; flat address is zero
//   whenever status is not ok.
`timescale 1ns / 1ps
`default_nettype none

module x86_segment_address_translate_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire x86sat_pkg::t_req i_item,
    output logic                  o_valid,
    output x86sat_pkg::t_rsp      o_result
);

    logic              r_in_vld;
    x86sat_pkg::t_req  r_in;
    x86sat_pkg::t_mid  mid;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_item;
    end

    x86sat_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_req   (r_in),
        .o_mid   (mid)
    );

    x86sat_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mid    (mid),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // Every result traces back to a transfer through the input, check and merge registers.
    a_result_origin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3))
        else $error("result without matching transfer");

    // A failed check never exposes an address.
    a_fault_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != x86sat_pkg::ST_OK) |-> (o_result.flat_address == '0))
        else $error("faulting result carries an address");

    // Real mode and unchecked translates always succeed.
    a_never_fail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.real_or_v86
                            || i_item.operation == x86sat_pkg::OP_RAW
                            || i_item.operation == x86sat_pkg::OP_SPARE))
        |-> ##3 (o_valid && o_result.status == x86sat_pkg::ST_OK))
        else $error("unchecked access reported a fault");

    // A real-mode address never exceeds 32 bits.
    a_real_wrap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.real_or_v86) |-> ##3 (o_result.flat_address[63:32] == '0))
        else $error("real-mode address not wrapped");

endmodule

`default_nettype wire

>>> tb/sv/x86_segment_address_translate_unit_tb.sv
// Testbench for the x86 segment address translate unit.
// Drives directed and random accesses, predicts each flat address and status.
// Depends on x86sat_pkg and x86_segment_address_translate_unit.
`timescale 1ns / 1ps

module x86_segment_address_translate_unit_tb;

    localparam logic [x86sat_pkg::AttrW-1:0] A_S = 7'(1) << x86sat_pkg::ATTR_S;
    localparam logic [x86sat_pkg::AttrW-1:0] A_P = 7'(1) << x86sat_pkg::ATTR_P;
    localparam logic [x86sat_pkg::AttrW-1:0] A_G = 7'(1) << x86sat_pkg::ATTR_G;

    // Descriptor type codes used by the directed accesses.
    localparam logic [3:0] TYPE_DATA_RW   = 4'h2;
    localparam logic [3:0] TYPE_DATA_DOWN = 4'h6;
    localparam logic [3:0] TYPE_CODE_RX   = 4'hA;

    localparam logic [2:0] SEG_ES = 3'd0;
    localparam logic [2:0] SEG_CS = 3'd1;
    localparam logic [2:0] SEG_DS = 3'd3;
    localparam logic [2:0] SEG_SPARE = 3'd7;

    localparam int RANDOM_ACCESSES = 2000;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    x86sat_pkg::t_req  i_item;
    logic              o_valid;
    x86sat_pkg::t_rsp  o_result;

    x86sat_pkg::t_rsp  pending_translations[$];
    int                mismatches;
    int                burst_left;

    x86_segment_address_translate_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic x86sat_pkg::t_rsp predict_translation(input x86sat_pkg::t_req r);
        x86sat_pkg::t_rsp res;
        logic [3:0]       dtype;
        logic             wide;
        logic [31:0]      seg16;
        dtype = r.seg_attr[3:0];
        wide  = r.cs_long && r.long_mode_active;
        res.status = x86sat_pkg::ST_OK;
        if (r.real_or_v86) begin
            seg16 = r.hidden_valid ? r.seg_base[31:0] : {12'h0, r.selector, 4'h0};
            res.flat_address = {32'h0, 32'(r.address[15:0]) + seg16};
        end else if (r.operation == x86sat_pkg::OP_CODE) begin
            res.flat_address = '0;
            if (!r.seg_attr[x86sat_pkg::ATTR_P])
                res.status = x86sat_pkg::ST_NOT_PRESENT;
            else if (!r.seg_attr[x86sat_pkg::ATTR_S] || !dtype[x86sat_pkg::ATTR_CODE])
                res.status = x86sat_pkg::ST_NOT_CODE;
            else if (wide)
                res.flat_address = r.address;
            else if (r.address[31:0] <= r.seg_limit)
                res.flat_address = {32'h0, r.address[31:0] + r.seg_base[31:0]};
            else
                res.status = x86sat_pkg::ST_BOUNDS;
        end else begin
            if (!wide)
                res.flat_address = {32'h0, r.seg_base[31:0] + r.address[31:0]};
            else if (r.seg_index == x86sat_pkg::SEG_FS || r.seg_index == x86sat_pkg::SEG_GS)
                res.flat_address = r.seg_base + r.address;
            else
                res.flat_address = r.address;
            if (r.operation == x86sat_pkg::OP_DATA) begin
                if (!r.seg_attr[x86sat_pkg::ATTR_P]) begin
                    res.status = x86sat_pkg::ST_NOT_PRESENT;
                end else if (!wide) begin
                    // expand-down data: types 4 to 7
                    if (dtype[3:2] == 2'b01) begin
                        if (!r.seg_attr[x86sat_pkg::ATTR_G] && r.address > 64'hffff)
                            res.status = x86sat_pkg::ST_BOUNDS;
                        else if (r.address <= {32'h0, r.seg_limit})
                            res.status = x86sat_pkg::ST_BOUNDS;
                    end else if (r.address > {32'h0, r.seg_limit}) begin
                        res.status = x86sat_pkg::ST_BOUNDS;
                    end
                end
                if (res.status != x86sat_pkg::ST_OK)
                    res.flat_address = '0;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Inputs change on the falling edge; start stays high across back-to-back transfers.
    task automatic send_access(input x86sat_pkg::t_req r);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else if ($urandom_range(0, 15) == 0) begin
            gap = 0;
            burst_left = $urandom_range(8, 40);
        end else begin
            gap = $urandom_range(0, 14);
        end
        if (gap != 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = r;
        do @(posedge i_clk); while (busy);
        pending_translations.push_back(predict_translation(r));
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        x86sat_pkg::t_rsp exp_rsp;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_translations.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h/%0d",
                                          o_result.flat_address, o_result.status));
            end else begin
                exp_rsp = pending_translations.pop_front();
                if (o_result.flat_address !== exp_rsp.flat_address)
                    report_mismatch($sformatf("flat_address %h, want %h",
                                              o_result.flat_address, exp_rsp.flat_address));
                if (o_result.status !== exp_rsp.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_result.status, exp_rsp.status));
            end
        end
    end

    function automatic x86sat_pkg::t_req make_access(input logic [1:0] op, input logic rm,
                                         input logic lma, input logic csl,
                                         input logic [2:0] idx, input logic [15:0] sel,
                                         input logic [63:0] base, input logic [31:0] limit,
                                         input logic [6:0] attr, input logic hv,
                                         input logic [63:0] addr);
        x86sat_pkg::t_req r;
        r.operation        = op;
        r.real_or_v86      = rm;
        r.long_mode_active = lma;
        r.cs_long          = csl;
        r.seg_index        = idx;
        r.selector         = sel;
        r.seg_base         = base;
        r.seg_limit        = limit;
        r.seg_attr         = attr;
        r.hidden_valid     = hv;
        r.address          = addr;
        return r;
    endfunction

    task automatic test_real_mode();
        send_access(make_access(x86sat_pkg::OP_DATA, 1, 0, 0, SEG_DS, 16'h1234,
                                64'hffff_ffff_ffff_fff0,
                                32'h0, 7'h00, 1, 64'hffff_ffff_ffff_ffff));
        send_access(make_access(x86sat_pkg::OP_CODE, 1, 1, 1, SEG_CS, 16'hffff, 64'h0,
                                32'h0, 7'h00, 0, 64'h0000_0000_0001_ffff));
        send_access(make_access(x86sat_pkg::OP_RAW, 1, 0, 0, SEG_ES, 16'h0000, 64'h0,
                                32'h0, 7'h7f, 0, 64'h0));
        send_access(make_access(x86sat_pkg::OP_SPARE, 1, 0, 1, x86sat_pkg::SEG_GS, 16'h8000,
                                64'h0000_0001_8000_0000,
                                32'hffff_ffff, 7'h00, 1, 64'h8000_0000_0000_8000));
    endtask

    task automatic test_code_validate();
        send_access(make_access(x86sat_pkg::OP_CODE, 0, 0, 0, SEG_CS, 16'h8, 64'h1000,
                                32'hffff_ffff, A_S | 7'(TYPE_CODE_RX), 1, 64'h10));
        send_access(make_access(x86sat_pkg::OP_CODE, 0, 0, 0, SEG_CS, 16'h8, 64'h1000,
                                32'hffff_ffff, A_P | 7'(TYPE_CODE_RX), 1, 64'h10));
        send_access(make_access(x86sat_pkg::OP_CODE, 0, 0, 0, SEG_CS, 16'h8, 64'h1000,
                                32'hffff_ffff, A_P | A_S | 7'(TYPE_DATA_RW), 1, 64'h10));
        send_access(make_access(x86sat_pkg::OP_CODE, 0, 1, 1, SEG_CS, 16'h8,
                                64'hdead_0000_0000,
                                32'h0, A_P | A_S | 7'(TYPE_CODE_RX), 1,
                                64'hffff_8000_1234_5678));
        send_access(make_access(x86sat_pkg::OP_CODE, 0, 0, 0, SEG_CS, 16'h8, 64'h1_ffff_f000,
                                32'h0000_8000, A_P | A_S | 7'(TYPE_CODE_RX), 1,
                                64'hffff_0000_0000_8000));
        send_access(make_access(x86sat_pkg::OP_CODE, 0, 0, 0, SEG_CS, 16'h8, 64'h1000,
                                32'h0000_8000, A_P | A_S | 7'(TYPE_CODE_RX), 1, 64'h8001));
        send_access(make_access(x86sat_pkg::OP_CODE, 0, 1, 0, SEG_CS, 16'h8,
                                64'hffff_ffff_ffff_ffff,
                                32'hffff_ffff, 7'h7f, 1, 64'hffff_ffff));
    endtask

    task automatic test_data_checks();
        send_access(make_access(x86sat_pkg::OP_DATA, 0, 0, 0, SEG_DS, 16'h10, 64'h2000,
                                32'hffff, A_S | 7'(TYPE_DATA_RW), 1, 64'h100));
        send_access(make_access(x86sat_pkg::OP_DATA, 0, 0, 0, SEG_DS, 16'h10, 64'hffff_f000,
                                32'hffff, A_P | A_S | 7'(TYPE_DATA_RW), 1, 64'hffff));
        send_access(make_access(x86sat_pkg::OP_DATA, 0, 0, 0, SEG_DS, 16'h10, 64'h2000,
                                32'hffff, A_P | A_S | 7'(TYPE_DATA_RW), 1, 64'h1_0000));
        // upper offset bits count against the limit
        send_access(make_access(x86sat_pkg::OP_DATA, 0, 0, 0, SEG_DS, 16'h10, 64'h0,
                                32'hffff_ffff, A_P | A_S | 7'(TYPE_DATA_RW), 1,
                                64'h1_0000_0000));
        send_access(make_access(x86sat_pkg::OP_DATA, 0, 0, 0, SEG_ES, 16'h18, 64'h0,
                                32'h100, A_P | A_S | 7'(TYPE_DATA_DOWN), 1, 64'h1_0000));
        send_access(make_access(x86sat_pkg::OP_DATA, 0, 0, 0, SEG_ES, 16'h18, 64'h5000,
                                32'hfff, A_P | A_S | 7'(TYPE_DATA_DOWN), 1, 64'hffff));
        send_access(make_access(x86sat_pkg::OP_DATA, 0, 0, 0, SEG_ES, 16'h18, 64'h5000,
                                32'h1000, A_P | A_S | A_G | 7'(TYPE_DATA_DOWN), 1,
                                64'h2_0000));
        send_access(make_access(x86sat_pkg::OP_DATA, 0, 0, 0, SEG_ES, 16'h18, 64'h5000,
                                32'h1000, A_P | A_G | 7'(TYPE_DATA_DOWN), 1, 64'h1000));
    endtask

    task automatic test_long_mode();
        send_access(make_access(x86sat_pkg::OP_DATA, 0, 1, 1, x86sat_pkg::SEG_FS, 16'h0,
                                64'hffff_ffff_ffff_ff00,
                                32'h0, A_P | A_S | 7'(TYPE_DATA_RW), 1, 64'h200));
        send_access(make_access(x86sat_pkg::OP_RAW, 0, 1, 1, x86sat_pkg::SEG_GS, 16'h0,
                                64'h8000_0000_0000_0000,
                                32'h0, 7'h00, 1, 64'h0000_7fff_ffff_ffff));
        send_access(make_access(x86sat_pkg::OP_RAW, 0, 1, 1, SEG_SPARE, 16'h0,
                                64'h1234_5678_9abc_def0,
                                32'h0, 7'h00, 0, 64'hfedc_ba98_7654_3210));
        send_access(make_access(x86sat_pkg::OP_DATA, 0, 1, 1, SEG_DS, 16'h0, 64'h1000, 32'h0,
                                A_S | 7'(TYPE_DATA_RW), 1, 64'h10));
        send_access(make_access(x86sat_pkg::OP_DATA, 0, 1, 0, SEG_DS, 16'h2b,
                                64'h0000_0001_ffff_fff0,
                                32'hffff_ffff, A_P | A_S | 7'(TYPE_DATA_RW), 1, 64'h20));
        send_access(make_access(x86sat_pkg::OP_SPARE, 0, 0, 0, SEG_SPARE, 16'h0, 64'h1000,
                                32'h0, 7'h00, 0, 64'hffff_ffff_ffff_ffff));
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_random_accesses();
        x86sat_pkg::t_req r;
        for (int n = 0; n < RANDOM_ACCESSES; n++) begin
            r.operation        = 2'($urandom_range(0, 3));
            r.real_or_v86      = ($urandom_range(0, 4) == 0);
            r.long_mode_active = 1'($urandom);
            r.cs_long          = 1'($urandom);
            r.seg_index        = 3'($urandom);
            r.selector         = 16'($urandom);
            r.hidden_valid     = 1'($urandom);
            r.seg_attr         = 7'($urandom);
            // mostly present, so that the limit and type checks are reached
            if ($urandom_range(0, 3) != 0)
                r.seg_attr[x86sat_pkg::ATTR_P] = 1'b1;
            case ($urandom_range(0, 2))
                0: r.seg_base = rand64();
                1: r.seg_base = {32'h0, $urandom};
                default: r.seg_base = 64'($urandom_range(0, 16'hffff));
            endcase
            r.seg_limit = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 20'hfffff);
            case ($urandom_range(0, 3))
                0: r.address = rand64();
                1: r.address = 64'($urandom_range(0, 18'h3ffff));
                2: r.address = {32'($urandom_range(0, 1)), r.seg_limit}
                               + 64'($urandom_range(0, 4)) - 64'd2;
                default: r.address = {32'h0, $urandom};
            endcase
            send_access(r);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        mismatches = 0;
        burst_left = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_real_mode();
        test_code_validate();
        test_data_checks();
        test_long_mode();
        test_random_accesses();

        start = 1'b0;
        for (int n = 0; n < 64 && pending_translations.size() != 0; n++)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        while (pending_translations.size() != 0) begin
            report_mismatch("expected result never arrived");
            void'(pending_translations.pop_front());
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
